FILE: hw/rtl/rsm_pkg.sv
`timescale 1ns / 1ps
package rsm_pkg;
  typedef struct packed {
    logic signed [15:0] element_value;
    logic               last_in_row;
  } rsm_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        last_out;
    logic        row_overflow;
  } rsm_out_t;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction
endpackage

FILE: hw/rtl/rsm_exp.sv
`timescale 1ns / 1ps
// exp(-d) in Q1.16, three register stages
module rsm_exp (
  input  logic        clk,
  input  logic [15:0] d,
  output logic [16:0] e
);
  import rsm_pkg::*;

  logic [32:0] prod_r;
  logic [16:0] t_hi_r, t_lo_r;
  logic [11:0] frac_r;
  logic [16:0] ip_r;
  logic [16:0] m;
  logic [16:0] diff;
  logic [28:0] dr;
  logic [16:0] mq_r;
  logic [16:0] ip2_r;
  logic [24:0] t;
  logic [17:0] rnd;
  logic [17:0] mm;

  assign t = 25'((prod_r + 33'd128) >> 8);

  always_ff @(posedge clk) begin
    prod_r <= 33'(d) * 33'(LOG2E_Q16);
    t_hi_r <= pow2_neg({1'b0, t[15:12]});
    t_lo_r <= pow2_neg({1'b0, t[15:12]} + 5'd1);
    frac_r <= t[11:0];
    ip_r   <= {8'd0, t[24:16]};
    mq_r   <= m;
    ip2_r  <= ip_r;
  end

  always_comb begin
    diff = t_hi_r - t_lo_r;
    dr   = 29'(diff) * 29'(frac_r) + 29'd2048;
    m    = t_hi_r - 17'(dr >> 12);
    rnd  = '0;
    mm   = '0;
    if (ip2_r >= 17'd17) begin
      e = '0;
    end else if (ip2_r == 17'd0) begin
      e = mq_r;
    end else begin
      rnd = 18'd1 << (ip2_r[4:0] - 5'd1);
      mm  = 18'(mq_r) + rnd;
      e   = 17'(mm >> ip2_r[4:0]);
    end
  end
endmodule

FILE: hw/rtl/rsm_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module rsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [22:0] den,
  output logic        done,
  output logic [15:0] quo
);
  logic [39:0] q_r, q_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] trial;

  assign done = done_r;
  assign quo  = (q_r[39:16] != 24'd0) ? 16'hFFFF : q_r[15:0];

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = 6'd40; busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[39]} - {2'b0, den};
      if (!trial[24]) begin
        rem_nxt = trial[23:0];
        q_nxt   = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[22:0], q_r[39]};
        q_nxt   = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end
endmodule

FILE: hw/rtl/row_softmax.sv
`timescale 1ns / 1ps
// Elements are stored at one per cycle while the row is open, up to MAX_COLS; later ones are dropped.
// On the last element: an exp pass over the stored elements, then per element a
// serial divide plus output; each divide starts only after the last result is registered.
// Not ready during the exp, divide and output passes.
// Reset (synchronous, rst_n low) empties the row; stores stay undefined.
module row_softmax #(
  parameter int MAX_COLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsm_pkg::rsm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsm_pkg::rsm_out_t out_data
);
  import rsm_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam logic [2:0] S_LOAD = 3'd0, S_EXP = 3'd1, S_DIV = 3'd2,
                         S_WAIT = 3'd3, S_OUT = 3'd4;

  logic [15:0] row_mem [MAX_COLS];
  logic [16:0] exp_mem [MAX_COLS];

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] widx_r, widx_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [22:0] sum_r, sum_nxt;
  logic        ovf_r, ovf_nxt;
  logic [3:0]  vld_r, vld_nxt;
  logic [15:0] rd_row_r;
  logic [16:0] rd_exp_r;
  logic [15:0] d;
  logic [16:0] e;
  logic        div_start;
  logic        div_done;
  logic [15:0] quo;
  rsm_out_t    out_r, out_nxt;
  logic        ov_r, ov_nxt;
  logic        acc;

  rsm_exp u_exp (.clk(clk), .d(d), .e(e));
  rsm_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
                 .num({7'd0, rd_exp_r, 16'd0} + {17'd0, 1'b0, sum_r[22:1]}),
                 .den(sum_r), .done(div_done), .quo(quo));

  assign in_ready  = (state_r == S_LOAD);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign d = 16'(max_r - $signed(rd_row_r));

  always_ff @(posedge clk) begin
    if (acc && cnt_r < CW'(MAX_COLS)) row_mem[cnt_r[AW-1:0]] <= in_data.element_value;
    rd_row_r <= row_mem[idx_r[AW-1:0]];
    if (state_r == S_EXP && vld_r[3]) exp_mem[widx_r[AW-1:0]] <= e;
    rd_exp_r <= exp_mem[idx_nxt[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; widx_nxt = widx_r;
    max_nxt = max_r; sum_nxt = sum_r; ovf_nxt = ovf_r; vld_nxt = vld_r;
    out_nxt = out_r; ov_nxt = ov_r; div_start = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: if (acc) begin
        if (cnt_r < CW'(MAX_COLS)) begin
          cnt_nxt = cnt_r + CW'(1);
          if (in_data.element_value > max_r) max_nxt = in_data.element_value;
        end else ovf_nxt = 1'b1;
        if (in_data.last_in_row) begin
          state_nxt = S_EXP; idx_nxt = '0; widx_nxt = '0; sum_nxt = '0; vld_nxt = '0;
        end
      end
      S_EXP: begin
        // elements in flight through the read register and the exp stages
        vld_nxt = {vld_r[2:0], idx_r < cnt_r};
        if (idx_r < cnt_r) idx_nxt = idx_r + CW'(1);
        if (vld_r[3]) begin
          sum_nxt  = sum_r + 23'(e);
          widx_nxt = widx_r + CW'(1);
        end
        if (vld_r == 4'd0 && idx_r >= cnt_r && idx_r != '0) begin
          state_nxt = S_DIV; idx_nxt = '0;
        end
      end
      S_DIV: begin
        div_start = 1'b1; state_nxt = S_WAIT;
      end
      S_WAIT: if (div_done) state_nxt = S_OUT;
      S_OUT: if (!ov_r || out_ready) begin
        ov_nxt = 1'b1;
        out_nxt.probability  = quo;
        out_nxt.last_out     = (idx_r + CW'(1) == cnt_r);
        out_nxt.row_overflow = ovf_r;
        if (idx_r + CW'(1) == cnt_r) begin
          state_nxt = S_LOAD; cnt_nxt = '0; max_nxt = 16'sh8000;
          sum_nxt = '0; ovf_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + CW'(1); state_nxt = S_DIV;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; widx_r <= widx_nxt; sum_r <= sum_nxt; out_r <= out_nxt;
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; max_r <= 16'sh8000; ovf_r <= 1'b0;
      vld_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; max_r <= max_nxt; ovf_r <= ovf_nxt;
      vld_r <= vld_nxt; ov_r <= ov_nxt;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_COLS)) else $error("count overrun");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> !in_ready) else $error("ready during divide");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while waiting");
endmodule

FILE: test/row_softmax_test.sv
`timescale 1ns / 1ps
module row_softmax_test;
  import rsm_pkg::*;

  localparam int COLS = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  rsm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rsm_out_t out_data;

  row_softmax #(.MAX_COLS(COLS)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] row_buf [COLS];
  logic [16:0] term_buf [COLS];
  int unsigned row_len;
  logic signed [15:0] row_peak;
  logic row_dropped;
  rsm_out_t prob_queue [$];

  int errors = 0;
  int quiet_cycles = 0;
  bit idle_on = 1;

  localparam int unsigned EXP_TAB [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic logic [16:0] exp_term(input logic [15:0] d);
    logic [63:0] t;
    int unsigned ip, f, k, r, hi, lo, m;
    t = ({48'd0, d} * 64'd94548 + 64'd128) >> 8;
    ip = 32'(t >> 16);
    f = 32'(t & 64'hFFFF);
    k = f >> 12;
    r = f & 12'hFFF;
    hi = EXP_TAB[k];
    lo = EXP_TAB[k + 1];
    m = hi - (((hi - lo) * r + 2048) >> 12);
    if (ip >= 17) return 17'd0;
    if (ip == 0) return m[16:0];
    return 17'((m + (1 << (ip - 1))) >> ip);
  endfunction

  task automatic predict_row(input rsm_in_t it);
    logic [22:0] total;
    logic [63:0] p;
    rsm_out_t res;
    if (row_len < COLS) begin
      row_buf[row_len] = it.element_value;
      row_len++;
      if (it.element_value > row_peak) row_peak = it.element_value;
    end else begin
      row_dropped = 1;
    end
    if (!it.last_in_row) return;
    total = 0;
    for (int j = 0; j < row_len; j++) begin
      term_buf[j] = exp_term(16'(32'(row_peak) - 32'(row_buf[j])));
      total = total + 23'(term_buf[j]);
    end
    for (int j = 0; j < row_len; j++) begin
      p = (({47'd0, term_buf[j]} << 16) + 64'(total >> 1)) / 64'(total);
      if (p > 65535) p = 65535;
      res.probability = p[15:0];
      res.last_out = (j + 1 == row_len);
      res.row_overflow = row_dropped;
      prob_queue.push_back(res);
    end
    row_len = 0;
    row_peak = -16'sd32768;
    row_dropped = 0;
  endtask

  task automatic send_element(input logic signed [15:0] v, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    in_data.element_value = v;
    in_data.last_in_row = last;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_row('{element_value: v, last_in_row: last});
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_row(input int n, input int spread);
    for (int i = 0; i < n; i++)
      send_element(16'($urandom_range(0, spread) - spread / 2), i == n - 1);
  endtask

  task automatic drain();
    while (prob_queue.size() != 0) @(negedge clk);
  endtask

  task test_extremes();
    send_element(16'sh7FFF, 1);
    send_element(-16'sd32768, 1);
    send_element(-16'sd32768, 0);
    send_element(16'sh7FFF, 1);
    send_element(16'sd0, 0);
    send_element(16'sd0, 0);
    send_element(16'sd256, 1);
    send_element(16'sh5555, 0);
    send_element(16'shAAAA, 0);
    send_element(16'sd100, 1);
  endtask

  task test_overflow();
    // 66 elements: the last two are dropped, the final one still ends the row
    for (int i = 0; i < 66; i++) send_element(16'($urandom), i == 65);
  endtask

  task test_random();
    for (int r = 0; r < 5; r++) begin
      send_row($urandom_range(1, 8), $urandom_range(0, 1) ? 4095 : 65535);
      if (r == 2) drain();
    end
  endtask

  task test_no_idle();
    drain();
    idle_on = 0;
    for (int r = 0; r < 4; r++) send_row($urandom_range(1, 6), 8191);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    out_ready <= 1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (prob_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        if (out_data !== prob_queue[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp prob %0d last %b ovf %b, got prob %0d last %b ovf %b",
              prob_queue[0].probability, prob_queue[0].last_out,
              prob_queue[0].row_overflow, out_data.probability, out_data.last_out,
              out_data.row_overflow);
        end
        void'(prob_queue.pop_front());
      end
    end
  end

  initial begin
    row_len = 0;
    row_peak = -16'sd32768;
    row_dropped = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    test_extremes();
    test_overflow();
    test_random();
    test_no_idle();
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0 && prob_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
